// ===== hw/rtl/tslc_pkg.sv =====
// Shared types and constants of the token sequence linear classifier.
`default_nettype none

package tslc_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned BANK_W  = 64;
  localparam int unsigned NUM_BANKS = 4;
  localparam int unsigned WGT_W   = 16;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned PROD_W  = VAL_W + WGT_W;
  localparam int unsigned SUM_W   = 56;
  localparam int unsigned BIAS_W  = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = BANK_W;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'd0;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
  localparam logic [BYTE_W-1:0] CH_NL    = 8'd10;
  localparam logic [BYTE_W-1:0] CH_VT    = 8'd11;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'd12;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'd43;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'd44;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'd45;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'd57;

  localparam logic [VAL_W-1:0] VALUE_CAP = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    FP_PRE    = 3'd0,
    FP_FIRST  = 3'd1,
    FP_GAP    = 3'd2,
    FP_SECOND = 3'd3,
    FP_DONE   = 3'd4
  } fpos_e;

  typedef enum logic [1:0] {
    TP_NONE  = 2'd0,
    TP_BLANK = 2'd1,
    TP_NUM   = 2'd2,
    TP_STOP  = 2'd3
  } tphase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BANK_A = 3'd0,
    CFG_BANK_B = 3'd1,
    CFG_BANK_C = 3'd2,
    CFG_BANK_D = 3'd3,
    CFG_BIAS   = 3'd4,
    CFG_LABEL  = 3'd5
  } cfg_idx_e;

  typedef logic [NUM_BANKS-1:0][BANK_W-1:0] banks_t;

  typedef struct packed {
    logic valid;
    logic add;
    logic line_end;
  } evt_t;

  function automatic logic signed [WGT_W-1:0] weight_at(banks_t banks, logic [3:0] sel);
    logic [BANK_W-1:0] bank;
    bank = banks[sel[3:2]];
    return $signed(bank[WGT_W*sel[1:0] +: WGT_W]);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tslc_parse.sv =====
// Byte parser: field and token tracking, atoi conversion and weight selection.
`default_nettype none

module tslc_parse #(
  parameter int unsigned ELEMENTS_PER_LINE = 100,
  parameter int unsigned WEIGHT_COUNT = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                adv_i,
  input  wire logic                                in_valid_i,
  input  wire logic [tslc_pkg::BYTE_W-1:0]         text_byte_i,
  input  wire logic                                last_byte_i,
  input  wire tslc_pkg::banks_t                    banks_i,
  output tslc_pkg::evt_t                           evt_o,
  output logic signed [tslc_pkg::VAL_W-1:0]        value_o,
  output logic signed [tslc_pkg::WGT_W-1:0]        weight_o
);
  import tslc_pkg::*;

  localparam int unsigned EC_W = $clog2(ELEMENTS_PER_LINE + 1);
  localparam int unsigned WI_W = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;

  fpos_e             fp_q, fp_d;
  tphase_e           tph_q, tph_d, cl_phase;
  logic              neg_q, neg_d, cl_neg;
  logic [VAL_W-1:0]  val_q, val_d, cl_val;
  logic [EC_W-1:0]   ec_q, ec_d;
  logic [WI_W-1:0]   wi_q, wi_d;

  logic              accept;
  logic              is_nl;
  logic              line_end;
  logic              is_digit;
  logic              is_blank;
  logic [3:0]        digit;
  logic [VAL_W+3:0]  grown;
  logic [VAL_W-1:0]  digit_val;
  logic              tok_en;
  logic              close_cur;
  logic              close_any;
  logic              add;
  logic [VAL_W-1:0]  value;

  evt_t                      evt_q;
  logic signed [VAL_W-1:0]   value_q;
  logic signed [WGT_W-1:0]   weight_q;

  assign accept   = in_valid_i && adv_i;
  assign is_nl    = (text_byte_i == CH_NL);
  assign line_end = is_nl || last_byte_i;
  assign is_digit = (text_byte_i >= CH_ZERO) && (text_byte_i <= CH_NINE);
  assign is_blank = (text_byte_i == CH_TAB) || (text_byte_i == CH_VT) ||
                    (text_byte_i == CH_FF) || (text_byte_i == CH_CR);
  assign digit    = 4'(text_byte_i - CH_ZERO);
  assign grown    = {4'b0, val_q} * 36'd10 + {32'b0, digit};
  assign digit_val = (grown > {4'b0, VALUE_CAP}) ? VALUE_CAP : grown[VAL_W-1:0];

  always_comb begin
    fp_d      = fp_q;
    tph_d     = tph_q;
    neg_d     = neg_q;
    val_d     = val_q;
    ec_d      = ec_q;
    wi_d      = wi_q;
    tok_en    = 1'b0;
    close_cur = 1'b0;
    cl_phase  = TP_NONE;
    cl_neg    = 1'b0;
    cl_val    = '0;
    add       = 1'b0;

    if (!is_nl) begin
      if (text_byte_i == CH_NUL) begin
        close_cur = (fp_q == FP_SECOND);
        fp_d      = FP_DONE;
      end else begin
        unique case (fp_q)
          FP_PRE: begin
            if (text_byte_i != CH_COMMA) fp_d = FP_FIRST;
          end
          FP_FIRST: begin
            if (text_byte_i == CH_COMMA) fp_d = FP_GAP;
          end
          FP_GAP: begin
            if (text_byte_i != CH_COMMA) begin
              fp_d   = FP_SECOND;
              tok_en = 1'b1;
            end
          end
          FP_SECOND: begin
            if (text_byte_i == CH_COMMA) begin
              close_cur = 1'b1;
              fp_d      = FP_DONE;
            end else begin
              tok_en = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (tok_en) begin
      if (text_byte_i == CH_SPACE) begin
        close_cur = 1'b1;
      end else if (tph_q == TP_NONE || tph_q == TP_BLANK) begin
        if (is_blank) begin
          tph_d = TP_BLANK;
        end else if (text_byte_i == CH_PLUS || text_byte_i == CH_MINUS) begin
          neg_d = (text_byte_i == CH_MINUS);
          tph_d = TP_NUM;
        end else if (is_digit) begin
          val_d = digit_val;
          tph_d = TP_NUM;
        end else begin
          tph_d = TP_STOP;
        end
      end else if (tph_q == TP_NUM) begin
        if (is_digit) begin
          val_d = digit_val;
        end else begin
          tph_d = TP_STOP;
        end
      end
    end

    if (close_cur) begin
      cl_phase = tph_q;
      cl_neg   = neg_q;
      cl_val   = val_q;
      tph_d    = TP_NONE;
      neg_d    = 1'b0;
      val_d    = '0;
    end else begin
      cl_phase = tph_d;
      cl_neg   = neg_d;
      cl_val   = val_d;
    end

    close_any = close_cur || (line_end && fp_d == FP_SECOND);
    add = close_any && (cl_phase != TP_NONE) && (ec_q < EC_W'(ELEMENTS_PER_LINE));
    if (add) begin
      ec_d = ec_q + EC_W'(1);
      wi_d = (wi_q == WI_W'(WEIGHT_COUNT - 1)) ? '0 : wi_q + WI_W'(1);
    end

    if (line_end) begin
      fp_d  = FP_PRE;
      tph_d = TP_NONE;
      neg_d = 1'b0;
      val_d = '0;
      ec_d  = '0;
      wi_d  = '0;
    end
  end

  assign value = cl_neg ? (VAL_W'(0) - cl_val) : (cl_val[VAL_W-1] ? VALUE_MAX : cl_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q  <= FP_PRE;
      tph_q <= TP_NONE;
      neg_q <= 1'b0;
      val_q <= '0;
      ec_q  <= '0;
      wi_q  <= '0;
      evt_q <= '0;
    end else if (adv_i) begin
      evt_q.valid    <= accept;
      evt_q.add      <= accept && add;
      evt_q.line_end <= accept && line_end;
      if (accept) begin
        fp_q  <= fp_d;
        tph_q <= tph_d;
        neg_q <= neg_d;
        val_q <= val_d;
        ec_q  <= ec_d;
        wi_q  <= wi_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      value_q  <= $signed(value);
      weight_q <= weight_at(banks_i, 4'(wi_q));
    end
  end

  assign evt_o    = evt_q;
  assign value_o  = value_q;
  assign weight_o = weight_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tslc_mac.sv =====
// Multiply stage and per-line accumulator of the weighted token sum.
`default_nettype none

module tslc_mac (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                adv_i,
  input  wire tslc_pkg::evt_t                      evt_i,
  input  wire logic signed [tslc_pkg::VAL_W-1:0]   value_i,
  input  wire logic signed [tslc_pkg::WGT_W-1:0]   weight_i,
  output logic                                     res_valid_o,
  output logic signed [tslc_pkg::SUM_W-1:0]        fin_sum_o
);
  import tslc_pkg::*;

  evt_t                     m_evt_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [SUM_W-1:0]  sum_next;
  logic signed [SUM_W-1:0]  fin_q;
  logic                     res_valid_q;

  assign sum_next = m_evt_q.add ? (sum_q + SUM_W'(prod_q)) : sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_evt_q     <= '0;
      sum_q       <= '0;
      res_valid_q <= 1'b0;
    end else if (adv_i) begin
      m_evt_q     <= evt_i;
      res_valid_q <= m_evt_q.valid && m_evt_q.line_end;
      if (m_evt_q.valid) begin
        sum_q <= m_evt_q.line_end ? '0 : sum_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= value_i * weight_i;
      fin_q  <= sum_next;
    end
  end

  assign res_valid_o = res_valid_q;
  assign fin_sum_o   = fin_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tslc_score.sv =====
// Bias scaling, threshold decision, confusion counters and the output register.
`default_nettype none

module tslc_score #(
  parameter int unsigned ELEMENTS_PER_LINE = 100
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                res_valid_i,
  input  wire logic signed [tslc_pkg::SUM_W-1:0]   fin_sum_i,
  input  wire logic signed [tslc_pkg::BIAS_W-1:0]  bias_i,
  input  wire logic                                label_i,
  input  wire logic                                out_stall_i,
  output logic                                     adv_o,
  output logic                                     out_valid_o,
  output logic                                     pred_o,
  output logic [tslc_pkg::CNT_W-1:0]               tp_o,
  output logic [tslc_pkg::CNT_W-1:0]               fp_o,
  output logic [tslc_pkg::CNT_W-1:0]               tn_o,
  output logic [tslc_pkg::CNT_W-1:0]               fn_o
);
  import tslc_pkg::*;

  localparam int unsigned EPL_W = $clog2(ELEMENTS_PER_LINE + 1);
  localparam int unsigned BS_W  = BIAS_W + EPL_W + 1;

  logic signed [EPL_W:0]    epl_s;
  logic signed [BS_W-1:0]   bs_d, bs_q;
  logic signed [SUM_W:0]    score;
  logic                     pred;
  logic                     load;
  logic                     out_valid_q;
  logic                     pred_q;
  logic [CNT_W-1:0]         tp_q, fp_q, tn_q, fn_q;

  assign epl_s = (EPL_W + 1)'(ELEMENTS_PER_LINE);
  assign bs_d  = bias_i * epl_s;
  assign score = (SUM_W + 1)'(fin_sum_i) + (SUM_W + 1)'(bs_q);
  assign pred  = !score[SUM_W] && (score != '0);

  assign adv_o = !(res_valid_i && out_valid_q && out_stall_i);
  assign load  = res_valid_i && adv_o;

  always_ff @(posedge clk_i) begin
    bs_q <= bs_d;
    if (load) pred_q <= pred;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      tp_q <= '0;
      fp_q <= '0;
      tn_q <= '0;
      fn_q <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        unique case ({pred, label_i})
          2'b11: tp_q <= (tp_q == '1) ? tp_q : tp_q + CNT_W'(1);
          2'b10: fp_q <= (fp_q == '1) ? fp_q : fp_q + CNT_W'(1);
          2'b00: tn_q <= (tn_q == '1) ? tn_q : tn_q + CNT_W'(1);
          default: fn_q <= (fn_q == '1) ? fn_q : fn_q + CNT_W'(1);
        endcase
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign pred_o      = pred_q;
  assign tp_o        = tp_q;
  assign fp_o        = fp_q;
  assign tn_o        = tn_q;
  assign fn_o        = fn_q;

endmodule

`default_nettype wire

// ===== hw/rtl/token_sequence_linear_classifier_core.sv =====
// Top level of the token sequence linear classifier with its configuration registers.
//
// The block takes one text byte per cycle and scores each finished line with a linear
// classifier: tokens of the second comma field are converted as decimal integers,
// multiplied by a cyclic set of Q3.12 weights and summed, and the line is flagged as
// anomalous when the sum plus ELEMENTS_PER_LINE times the Q19.12 bias is positive.
// A line ends at a newline byte or at a byte marked as last. Each finished line yields
// one item carrying the prediction and the four saturating confusion counts; other
// bytes yield nothing. The sustained rate is one byte per cycle while in_stall_o is
// low; a result passes the parser, multiply, line-result and output registers.
// in_stall_o is raised only while a line result waits in the output register under
// out_stall_i and the next line result has reached the scoring stage. The user
// writes registers through cfg_we_i, cfg_idx_i and cfg_data_i while no item is
// in flight, which the block does not enforce; a bias write passes bias_q and bs_q.
`default_nettype none

module token_sequence_linear_classifier_core #(
  parameter int unsigned ELEMENTS_PER_LINE = 100,
  parameter int unsigned WEIGHT_COUNT = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [tslc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [tslc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [tslc_pkg::BYTE_W-1:0]          text_byte_i,
  input  wire logic                                 last_byte_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic                                      predicted_anomaly_o,
  output logic [tslc_pkg::CNT_W-1:0]                true_pos_o,
  output logic [tslc_pkg::CNT_W-1:0]                false_pos_o,
  output logic [tslc_pkg::CNT_W-1:0]                true_neg_o,
  output logic [tslc_pkg::CNT_W-1:0]                false_neg_o
);
  import tslc_pkg::*;

  banks_t                    banks_q;
  logic signed [BIAS_W-1:0]  bias_q;
  logic                      label_q;

  logic                      adv;
  evt_t                      evt;
  logic signed [VAL_W-1:0]   value;
  logic signed [WGT_W-1:0]   weight;
  logic                      res_valid;
  logic signed [SUM_W-1:0]   fin_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      banks_q <= '0;
      bias_q  <= '0;
      label_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BANK_A: banks_q[0] <= cfg_data_i;
        CFG_BANK_B: banks_q[1] <= cfg_data_i;
        CFG_BANK_C: banks_q[2] <= cfg_data_i;
        CFG_BANK_D: banks_q[3] <= cfg_data_i;
        CFG_BIAS:   bias_q     <= $signed(cfg_data_i[BIAS_W-1:0]);
        CFG_LABEL:  label_q    <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  tslc_parse #(
    .ELEMENTS_PER_LINE(ELEMENTS_PER_LINE),
    .WEIGHT_COUNT(WEIGHT_COUNT)
  ) u_parse (
    .clk_i,
    .rst_ni,
    .adv_i      (adv),
    .in_valid_i,
    .text_byte_i,
    .last_byte_i,
    .banks_i    (banks_q),
    .evt_o      (evt),
    .value_o    (value),
    .weight_o   (weight)
  );

  tslc_mac u_mac (
    .clk_i,
    .rst_ni,
    .adv_i       (adv),
    .evt_i       (evt),
    .value_i     (value),
    .weight_i    (weight),
    .res_valid_o (res_valid),
    .fin_sum_o   (fin_sum)
  );

  tslc_score #(
    .ELEMENTS_PER_LINE(ELEMENTS_PER_LINE)
  ) u_score (
    .clk_i,
    .rst_ni,
    .res_valid_i (res_valid),
    .fin_sum_i   (fin_sum),
    .bias_i      (bias_q),
    .label_i     (label_q),
    .out_stall_i,
    .adv_o       (adv),
    .out_valid_o,
    .pred_o      (predicted_anomaly_o),
    .tp_o        (true_pos_o),
    .fp_o        (false_pos_o),
    .tn_o        (true_neg_o),
    .fn_o        (false_neg_o)
  );

  assign in_stall_o = !adv;

endmodule

`default_nettype wire

// ===== hw/rtl/tslc_checker.sv =====
// Port-level checks of the classifier core and their binding to the top level.
`default_nettype none

module tslc_checker (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [tslc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [tslc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                                 in_valid_i,
  input  wire logic                                 in_stall_o,
  input  wire logic [tslc_pkg::BYTE_W-1:0]          text_byte_i,
  input  wire logic                                 last_byte_i,
  input  wire logic                                 out_valid_o,
  input  wire logic                                 out_stall_i,
  input  wire logic                                 predicted_anomaly_o,
  input  wire logic [tslc_pkg::CNT_W-1:0]           true_pos_o,
  input  wire logic [tslc_pkg::CNT_W-1:0]           false_pos_o,
  input  wire logic [tslc_pkg::CNT_W-1:0]           true_neg_o,
  input  wire logic [tslc_pkg::CNT_W-1:0]           false_neg_o
);
  import tslc_pkg::*;

  logic unused_ok;
  assign unused_ok = cfg_we_i ^ (^cfg_idx_i) ^ (^cfg_data_i) ^ in_valid_i ^
                     (^text_byte_i) ^ last_byte_i;

  // The input side only stalls while a result is held back by the output side.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(predicted_anomaly_o) &&
      $stable(true_pos_o) && $stable(false_pos_o) && $stable(true_neg_o) &&
      $stable(false_neg_o)))
    else $error("stalled result changed");

  // Each line selects exactly one counter, which saturates, so at most one moves in any cycle.
  a_one_counter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({true_pos_o != $past(true_pos_o), false_pos_o != $past(false_pos_o),
                true_neg_o != $past(true_neg_o), false_neg_o != $past(false_neg_o)}) <= 1)
    else $error("more than one confusion counter changed");

  a_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (true_pos_o >= $past(true_pos_o)) && (false_pos_o >= $past(false_pos_o)) &&
    (true_neg_o >= $past(true_neg_o)) && (false_neg_o >= $past(false_neg_o)))
    else $error("confusion counter decreased");

  // A counter moves only when a new result is presented.
  a_count_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((true_pos_o != $past(true_pos_o)) || (false_pos_o != $past(false_pos_o)) ||
     (true_neg_o != $past(true_neg_o)) || (false_neg_o != $past(false_neg_o)))
    |-> out_valid_o)
    else $error("counter changed without a result");

endmodule

bind token_sequence_linear_classifier_core tslc_checker u_tslc_checker (.*);

`default_nettype wire
